// ===== rtl/core/plss_pkg.sv =====
// Shared types, codes and constants for the parallel LED string serializer.
package plss_pkg;

    localparam int DEF_LANES         = 6;
    localparam int DEF_LEDS_PER_LANE = 256;

    localparam int PIN_W       = 6;
    localparam int COLOR_SLOTS = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // input kind codes
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd4;

    localparam logic [7:0]  RST_BIT_PERIOD = 8'd90;
    localparam logic [7:0]  RST_SHORT_HIGH = 8'd29;
    localparam logic [7:0]  RST_LONG_HIGH  = 8'd59;
    localparam logic [15:0] RST_RESET_GAP  = 16'd3600;
    localparam logic [8:0]  RST_LED_COUNT  = 9'd256;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_START,
        OP_TICK,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] lane_index;
        logic [7:0] led_position;
        logic [1:0] color_slot;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             busy_res;
        logic             start_refused;
        logic             frame_done;
    } out_item_t;

    typedef struct packed {
        op_t      op;
        logic     wr_ok;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  bit_period_ticks;
        logic [7:0]  short_high_ticks;
        logic [7:0]  long_high_ticks;
        logic [15:0] reset_gap_ticks;
        logic [8:0]  led_count;
    } cfg_t;

endpackage

// ===== rtl/core/plss_front.sv =====
// Front end: takes input transfers and classifies them into queue commands.
module plss_front #(
    parameter int LANES         = plss_pkg::DEF_LANES,
    parameter int LEDS_PER_LANE = plss_pkg::DEF_LEDS_PER_LANE
) (
    input  logic               item_valid,
    output logic               item_stall,
    input  plss_pkg::in_item_t item,
    input  logic               queue_full,
    output logic               push,
    output plss_pkg::cmd_t     cmd
);
    import plss_pkg::*;

    op_t  op;
    logic wr_ok;

    always_comb
    begin
        unique case (item.kind)
            KIND_WRITE: op = OP_WRITE;
            KIND_START: op = OP_START;
            KIND_TICK:  op = OP_TICK;
            default:    op = OP_NONE;
        endcase
    end

    // writes outside the store are flagged here; the back end does not store them
    assign wr_ok = (int'(item.lane_index) < LANES)
                && (int'(item.color_slot) < COLOR_SLOTS)
                && (int'(item.led_position) < LEDS_PER_LANE);

    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;
    assign cmd        = '{op: op, wr_ok: wr_ok, item: item};

endmodule

// ===== rtl/core/plss_queue.sv =====
// Short command queue between the front end and the sequencer.
module plss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  plss_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output plss_pkg::cmd_t pop_data
);
    import plss_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_pop;

    assign full     = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/plss_back.sv =====
// Back end: frame store banks, bit slot sequencer and result register.
module plss_back #(
    parameter int LANES         = plss_pkg::DEF_LANES,
    parameter int LEDS_PER_LANE = plss_pkg::DEF_LEDS_PER_LANE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plss_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    input  plss_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output plss_pkg::out_item_t result
);
    import plss_pkg::*;

    localparam int CNT_W   = $clog2(LEDS_PER_LANE + 1);
    localparam int DEPTH   = LEDS_PER_LANE * COLOR_SLOTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RA_W    = CNT_W + 2;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [7:0]         slot_reg;
    logic [7:0]         slot_next;
    logic [2:0]         bitp_reg;
    logic [2:0]         bitp_next;
    logic [1:0]         bytep_reg;
    logic [1:0]         bytep_next;
    logic [CNT_W-1:0]   led_reg;
    logic [CNT_W-1:0]   led_next;
    logic [15:0]        gap_reg;
    logic [15:0]        gap_next;
    logic [LANES-1:0]   pins_reg;
    logic [LANES-1:0]   pins_next;
    logic [LANES-1:0]   lane_bits;
    logic [7:0]         rd_data_reg [LANES];

    out_item_t          result_reg;
    out_item_t          result_next;
    logic               result_valid_reg;

    logic               fire;
    logic               refused;
    logic               done;
    logic               rd_en;
    logic [RA_W-1:0]    rd_addr_w;
    logic [ADDR_W-1:0]  rd_addr;
    logic [9:0]         wr_addr_w;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;
    logic [CNT_W-1:0]   eff_count;
    logic [PIN_W-1:0]   pin_vec;

    assign fire    = cmd_valid && (!result_valid_reg || !result_stall);
    assign cmd_pop = fire;

    // led_count of zero sends one LED; counts above the store are clamped
    always_comb
    begin
        priority if (cfg.led_count == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (int'(cfg.led_count) > LEDS_PER_LANE)
        begin
            eff_count = CNT_W'(LEDS_PER_LANE);
        end
        else
        begin
            eff_count = CNT_W'(cfg.led_count);
        end
    end

    // write address = position * 3 + slot
    assign wr_addr_w = {1'b0, cmd.item.led_position, 1'b0}
                     + {2'b00, cmd.item.led_position}
                     + {8'd0, cmd.item.color_slot};
    assign wr_addr   = ADDR_W'(wr_addr_w);
    assign wr_en     = fire && (cmd.op == OP_WRITE) && cmd.wr_ok;

    // read address follows the counters after this command
    assign rd_addr_w = {1'b0, led_next, 1'b0} + {2'b00, led_next}
                     + {CNT_W'(0), bytep_next};
    assign rd_addr   = ADDR_W'(rd_addr_w);

    always_comb
    begin
        phase_next = phase_reg;
        slot_next  = slot_reg;
        bitp_next  = bitp_reg;
        bytep_next = bytep_reg;
        led_next   = led_reg;
        gap_next   = gap_reg;
        pins_next  = pins_reg;
        refused    = 1'b0;
        done       = 1'b0;
        rd_en      = 1'b0;
        if (fire)
        begin
            unique case (cmd.op)
                OP_START:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SEND;
                        slot_next  = '0;
                        bitp_next  = '0;
                        bytep_next = '0;
                        led_next   = '0;
                        gap_next   = '0;
                        pins_next  = '1;
                        rd_en      = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_SEND:
                        begin
                            slot_next = slot_reg + 8'd1;
                            if (slot_next == cfg.short_high_ticks)
                            begin
                                pins_next = pins_reg & ~lane_bits;
                            end
                            if (slot_next == cfg.long_high_ticks)
                            begin
                                pins_next = '0;
                            end
                            if (slot_next >= cfg.bit_period_ticks || slot_next == 8'd0)
                            begin
                                slot_next = '0;
                                bitp_next = bitp_reg + 3'd1;
                                if (bitp_reg == 3'd7)
                                begin
                                    if (bytep_reg == 2'd2)
                                    begin
                                        bytep_next = '0;
                                        led_next   = led_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        bytep_next = bytep_reg + 2'd1;
                                    end
                                end
                                if (led_next >= eff_count)
                                begin
                                    led_next  = '0;
                                    pins_next = '0;
                                    gap_next  = '0;
                                    if (cfg.reset_gap_ticks == '0)
                                    begin
                                        phase_next = PH_IDLE;
                                        done       = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_GAP;
                                    end
                                end
                                else
                                begin
                                    rd_en     = 1'b1;
                                    pins_next = '1;
                                end
                            end
                        end
                        PH_GAP:
                        begin
                            pins_next = '0;
                            gap_next  = gap_reg + 16'd1;
                            if (gap_next >= cfg.reset_gap_ticks)
                            begin
                                gap_next   = '0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // one byte-wide bank per lane, all read at the same address
    generate
        for (genvar g = 0; g < LANES; g++)
        begin : g_bank
            logic [7:0] mem [DEPTH];
            logic       bank_we;

            assign bank_we      = wr_en && (int'(cmd.item.lane_index) == g);
            assign lane_bits[g] = rd_data_reg[g][~bitp_reg];

            always_ff @(posedge clk)
            begin
                if (bank_we)
                begin
                    mem[wr_addr] <= cmd.item.byte_value;
                end
                if (rd_en)
                begin
                    rd_data_reg[g] <= mem[rd_addr];
                end
            end
        end

        for (genvar p = 0; p < PIN_W; p++)
        begin : g_pin
            if (p < LANES)
            begin : g_on
                assign pin_vec[p] = pins_next[p];
            end
            else
            begin : g_off
                assign pin_vec[p] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        result_next.pin_levels    = pin_vec;
        result_next.busy_res      = (phase_next != PH_IDLE);
        result_next.start_refused = refused;
        result_next.frame_done    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            slot_reg         <= '0;
            bitp_reg         <= '0;
            bytep_reg        <= '0;
            led_reg          <= '0;
            gap_reg          <= '0;
            pins_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            bitp_reg  <= bitp_next;
            bytep_reg <= bytep_next;
            led_reg   <= led_next;
            gap_reg   <= gap_next;
            pins_reg  <= pins_next;
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/parallel_led_string_serializer_top.sv =====
// Top level of the parallel LED string serializer: config registers and wiring.
//
// Drives up to LANES one-wire LED strings side by side from a per-lane frame store.
// Input channel (item_valid / item_stall / item): each transfer is a pixel byte write,
// a frame start or one clock tick; every item yields exactly one result transfer on
// result_valid / result_stall / result with the lane pin levels and status flags.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the timing
// registers; cfg_ready is always high. Write only while no frame is in flight.
// Throughput: one item per cycle while item_stall is low. An item taken is written into
// the command queue, is executed from there into the result register when the result
// side is not stalled, and its result transfer can then happen.
// A four-entry command queue sits between the input decode and the sequencer, so
// item_stall rises only after the receiver has held result_stall long enough to fill it;
// no result is dropped while stalled.
// Frame data lives in one memory bank per lane, read at a common address at each bit
// slot start; the registered read is ready before the first compare point of the slot.
// Reset clears the sequencer, queue and config registers (defaults 90/29/59/3600/256);
// frame store contents are undefined until written.
module parallel_led_string_serializer_top #(
    parameter int LANES         = plss_pkg::DEF_LANES,
    parameter int LEDS_PER_LANE = plss_pkg::DEF_LEDS_PER_LANE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  plss_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output plss_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import plss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic push;
    logic queue_full;
    logic queue_valid;
    logic pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BIT_PERIOD: cfg_next.bit_period_ticks = cfg_data[7:0];
                REG_SHORT_HIGH: cfg_next.short_high_ticks = cfg_data[7:0];
                REG_LONG_HIGH:  cfg_next.long_high_ticks  = cfg_data[7:0];
                REG_RESET_GAP:  cfg_next.reset_gap_ticks  = cfg_data;
                REG_LED_COUNT:  cfg_next.led_count        = cfg_data[8:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period_ticks <= RST_BIT_PERIOD;
            cfg_reg.short_high_ticks <= RST_SHORT_HIGH;
            cfg_reg.long_high_ticks  <= RST_LONG_HIGH;
            cfg_reg.reset_gap_ticks  <= RST_RESET_GAP;
            cfg_reg.led_count        <= RST_LED_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    plss_front #(
        .LANES         (LANES),
        .LEDS_PER_LANE (LEDS_PER_LANE)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    plss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .pop_data  (queue_cmd)
    );

    plss_back #(
        .LANES         (LANES),
        .LEDS_PER_LANE (LEDS_PER_LANE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (queue_valid),
        .cmd          (queue_cmd),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== tb/tb_parallel_led_string_serializer_top.sv =====
// Self-checking testbench for the parallel LED string serializer: directed and random items.
module tb_parallel_led_string_serializer_top;
    import plss_pkg::*;

    localparam int STRINGS      = DEF_LANES;
    localparam int LEDS         = DEF_LEDS_PER_LANE;
    localparam int STORE_SIZE   = STRINGS * LEDS * COLOR_SLOTS;
    localparam int BITS_PER_LED = 24;
    localparam int SETTLE       = 8;
    localparam int QUIET_MAX    = 2000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 60;
    localparam int REPORT_MAX   = 200;
    localparam logic [1:0] KIND_NOP = OP_NONE;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    in_item_t              item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // predicted block state
    logic [7:0]         pixel_mem [0:STORE_SIZE-1];
    cfg_t               timing    = '{RST_BIT_PERIOD, RST_SHORT_HIGH, RST_LONG_HIGH,
                                      RST_RESET_GAP, RST_LED_COUNT};
    phase_t             seq_phase = PH_IDLE;
    logic [7:0]         slot_tick = '0;
    logic [2:0]         bit_idx   = '0;
    logic [1:0]         byte_idx  = '0;
    logic [8:0]         led_idx   = '0;
    logic [15:0]        gap_tick  = '0;
    logic [STRINGS-1:0] ones_mask = '0;   // lanes whose current bit is 1
    logic [STRINGS-1:0] pin_state = '0;

    // stimulus bookkeeping
    in_item_t  pending_items [$];
    out_item_t expected_pins [$];
    bit        written [0:STORE_SIZE-1];
    int        frame_left  = 0;           // ticks until the frame in the queue is over
    int        items_taken = 0;
    int        mismatches  = 0;
    int        quiet       = 0;
    int        hold_left   = 0;
    bit        hold_used   = 1'b0;

    wire calm = items_taken >= 900 && items_taken < 1200;

    parallel_led_string_serializer_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int led_span(logic [8:0] n);
        if (n == 0)
            return 1;
        if (n > LEDS)
            return LEDS;
        return int'(n);
    endfunction

    function automatic void load_slot_bits();
        int addr;
        for (int l = 0; l < STRINGS; l++)
        begin
            addr = (l * LEDS + led_idx) * COLOR_SLOTS + byte_idx;
            ones_mask[l] = pixel_mem[addr][3'd7 - bit_idx];
        end
    endfunction

    function automatic out_item_t wave_step(in_item_t it);
        out_item_t res;
        res = '0;
        case (it.kind)
            KIND_WRITE:
                if (it.lane_index < STRINGS && it.color_slot < COLOR_SLOTS)
                    pixel_mem[(it.lane_index * LEDS + it.led_position) * COLOR_SLOTS
                              + it.color_slot] = it.byte_value;
            KIND_START:
                if (seq_phase != PH_IDLE)
                    res.start_refused = 1'b1;
                else
                begin
                    seq_phase = PH_SEND;
                    slot_tick = '0;
                    bit_idx   = '0;
                    byte_idx  = '0;
                    led_idx   = '0;
                    gap_tick  = '0;
                    load_slot_bits();
                    pin_state = '1;
                end
            KIND_TICK:
                if (seq_phase == PH_SEND)
                begin
                    slot_tick = slot_tick + 8'd1;
                    if (slot_tick == timing.short_high_ticks)
                        pin_state &= ~ones_mask;
                    if (slot_tick == timing.long_high_ticks)
                        pin_state = '0;
                    if (slot_tick >= timing.bit_period_ticks || slot_tick == 8'd0)
                    begin
                        slot_tick = '0;
                        bit_idx   = bit_idx + 3'd1;
                        if (bit_idx == 3'd0)
                        begin
                            if (byte_idx == 2'd2)
                            begin
                                byte_idx = '0;
                                led_idx  = led_idx + 9'd1;
                            end
                            else
                                byte_idx = byte_idx + 2'd1;
                        end
                        if (led_idx >= led_span(timing.led_count))
                        begin
                            led_idx   = '0;
                            pin_state = '0;
                            ones_mask = '0;
                            gap_tick  = '0;
                            if (timing.reset_gap_ticks == 16'd0)
                            begin
                                seq_phase      = PH_IDLE;
                                res.frame_done = 1'b1;
                            end
                            else
                                seq_phase = PH_GAP;
                        end
                        else
                        begin
                            load_slot_bits();
                            pin_state = '1;
                        end
                    end
                end
                else if (seq_phase == PH_GAP)
                begin
                    pin_state = '0;
                    gap_tick  = gap_tick + 16'd1;
                    if (gap_tick >= timing.reset_gap_ticks)
                    begin
                        gap_tick       = '0;
                        seq_phase      = PH_IDLE;
                        res.frame_done = 1'b1;
                    end
                end
            default: ;
        endcase
        res.pin_levels = pin_state;
        res.busy_res   = seq_phase != PH_IDLE;
        return res;
    endfunction

    function automatic in_item_t random_item(logic [1:0] k);
        in_item_t    it;
        logic [31:0] raw;
        raw     = $urandom;
        it      = raw[$bits(in_item_t)-1:0];
        it.kind = k;
        return it;
    endfunction

    // A start that will be taken first gets every byte of the frame written.
    function automatic void queue_item(in_item_t it);
        int       n;
        int       addr;
        in_item_t wr;
        if (it.kind == KIND_WRITE && it.lane_index < STRINGS && it.color_slot < COLOR_SLOTS)
            written[(it.lane_index * LEDS + it.led_position) * COLOR_SLOTS + it.color_slot] = 1'b1;
        if (it.kind == KIND_START && frame_left == 0)
        begin
            n = led_span(timing.led_count);
            for (int l = 0; l < STRINGS; l++)
                for (int p = 0; p < n; p++)
                    for (int s = 0; s < COLOR_SLOTS; s++)
                    begin
                        addr = (l * LEDS + p) * COLOR_SLOTS + s;
                        if (!written[addr])
                        begin
                            wr              = random_item(KIND_WRITE);
                            wr.lane_index   = 3'(l);
                            wr.led_position = 8'(p);
                            wr.color_slot   = 2'(s);
                            wr.byte_value   = 8'($urandom_range(255));
                            written[addr]   = 1'b1;
                            pending_items.push_back(wr);
                        end
                    end
            frame_left = n * BITS_PER_LED
                         * (timing.bit_period_ticks > 1 ? int'(timing.bit_period_ticks) : 1)
                         + int'(timing.reset_gap_ticks);
        end
        else if (it.kind == KIND_TICK && frame_left > 0)
            frame_left--;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_write(int lane, int pos, int slot, int val);
        in_item_t it;
        it              = random_item(KIND_WRITE);
        it.lane_index   = 3'(lane);
        it.led_position = 8'(pos);
        it.color_slot   = 2'(slot);
        it.byte_value   = 8'(val);
        queue_item(it);
    endfunction

    function automatic void finish_frame();
        while (frame_left > 0)
            queue_item(random_item(KIND_TICK));
    endfunction

    // Mostly whole frames with random content; the rest is noise and refused starts.
    function automatic void random_items(int count);
        in_item_t it;
        int       r;
        int       n;
        n = led_span(timing.led_count);
        repeat (count)
        begin
            r = $urandom_range(99);
            if ((frame_left == 0 && r < 30) || (frame_left != 0 && r >= 92 && r < 96))
                it = random_item(KIND_START);
            else if ((frame_left == 0 && r < 85) || (frame_left != 0 && r < 82))
                it = random_item(r < 65 && frame_left == 0 ? KIND_WRITE : KIND_TICK);
            else if (frame_left != 0 && r < 92)
                it = random_item(KIND_WRITE);
            else if ($urandom_range(1) == 0)
                it = random_item(KIND_NOP);
            else
            begin
                it = random_item(KIND_WRITE);
                if ($urandom_range(1) == 0)
                    it.lane_index = 3'(STRINGS + $urandom_range(7 - STRINGS));
                else
                    it.color_slot = 2'(COLOR_SLOTS);
                queue_item(it);
                continue;
            end
            if (it.kind == KIND_WRITE)
            begin
                it.lane_index   = 3'($urandom_range(STRINGS - 1));
                it.color_slot   = 2'($urandom_range(COLOR_SLOTS - 1));
                it.led_position = 8'($urandom_range(n > 255 ? 255 : n));
            end
            queue_item(it);
        end
    endfunction

    function automatic void report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    task automatic settle();
        while (pending_items.size() != 0 || item_valid || expected_pins.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BIT_PERIOD: timing.bit_period_ticks = val[7:0];
            REG_SHORT_HIGH: timing.short_high_ticks = val[7:0];
            REG_LONG_HIGH:  timing.long_high_ticks  = val[7:0];
            REG_RESET_GAP:  timing.reset_gap_ticks  = val[15:0];
            REG_LED_COUNT:  timing.led_count        = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_timing(int period, int short_pt, int long_pt, int gap, int count);
        settle();
        write_reg(REG_BIT_PERIOD, period);
        write_reg(REG_SHORT_HIGH, short_pt);
        write_reg(REG_LONG_HIGH, long_pt);
        write_reg(REG_RESET_GAP, gap);
        write_reg(REG_LED_COUNT, count);
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_pins.push_back(wave_step(item));
                items_taken <= items_taken + 1;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 24))
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pins.size() == 0)
                    report("unexpected result", '0, 32'(result));
                else
                begin
                    want = expected_pins.pop_front();
                    if (result.pin_levels !== want.pin_levels)
                        report("pin_levels", 32'(want.pin_levels), 32'(result.pin_levels));
                    if (result.busy_res !== want.busy_res)
                        report("busy_res", 32'(want.busy_res), 32'(result.busy_res));
                    if (result.start_refused !== want.start_refused)
                        report("start_refused", 32'(want.start_refused),
                               32'(result.start_refused));
                    if (result.frame_done !== want.frame_done)
                        report("frame_done", 32'(want.frame_done), 32'(result.frame_done));
                end
            end
            result_stall <= hold_left != 0 || (!calm && $urandom_range(99) < 24);
        end
    end

    // one long receiver hold-off so the command queue fills and the input stalls
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_used && items_taken >= HOLD_AT && pending_items.size() > 50)
        begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_MAX)
        begin
            $display("tb_parallel_led_string_serializer_top: errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes, ignored writes, unused kind, refused start, write mid-frame
        apply_timing(3, 1, 2, 2, 1);
        queue_write(0, 0, 0, 8'hFF);
        queue_write(5, 255, 2, 8'h00);
        queue_write(5, 0, 2, 8'h81);
        queue_write(7, 0, 0, 8'h55);
        queue_write(6, 3, 1, 8'hAA);
        queue_write(2, 0, 3, 8'h0F);
        queue_item(random_item(KIND_NOP));
        queue_item(random_item(KIND_TICK));
        queue_item(random_item(KIND_START));
        queue_item(random_item(KIND_START));
        queue_write(3, 0, 2, 8'hC3);
        queue_item(random_item(KIND_NOP));
        repeat (4) queue_item(random_item(KIND_TICK));
        finish_frame();

        apply_timing(2, 1, 1, 0, 1);
        random_items(80);
        finish_frame();
        apply_timing(5, 2, 4, 3, 2);
        random_items(120);
        finish_frame();
        apply_timing(0, 0, 0, 1, 0);
        random_items(80);
        finish_frame();
        apply_timing(1, 1, 1, 0, 3);
        random_items(80);
        finish_frame();
        apply_timing(4, 4, 6, 5, 1);      // neither compare point lands inside the slot
        random_items(80);
        finish_frame();
        apply_timing(6, 5, 3, 2, 2);
        random_items(100);
        finish_frame();
        apply_timing(8, 255, 255, 7, 1);
        random_items(80);
        finish_frame();
        apply_timing(3, 2, 1, 10, 4);
        random_items(150);
        finish_frame();

        apply_timing(90, 29, 59, 3600, 256);
        queue_item(random_item(KIND_NOP));

        apply_timing(4, 1, 3, 4, 2);
        random_items(150);
        finish_frame();

        settle();
        if (mismatches == 0)
            $display("tb_parallel_led_string_serializer_top: clean");
        else
            $display("tb_parallel_led_string_serializer_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/plss_pkg.sv
rtl/core/plss_front.sv
rtl/core/plss_queue.sv
rtl/core/plss_back.sv
rtl/core/parallel_led_string_serializer_top.sv
tb/tb_parallel_led_string_serializer_top.sv
